// ----- src/bslp_pkg.sv -----
// shared types, register codes and constants for the button press classifier
package bslp_pkg;

  localparam int unsigned BUTTONS_DEF = 8;

  // button index field and the number of buttons it can address
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned INDEX_SPAN = 1 << IDX_W;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // microsecond thresholds derived from millisecond limits
  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned THR_W     = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PRESS   = 2'd0,
    CFG_SHORT_LIMIT = 2'd1,
    CFG_LONG_LIMIT  = 2'd2
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] MIN_PRESS_RST   = 16'd30;
  localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = 16'd500;
  localparam logic [CFG_W-1:0] LONG_LIMIT_RST  = 16'd1000;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]  button_index;
    logic              level;
    logic [TIME_W-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic             press_kind;
    logic [IDX_W-1:0] button_number;
  } out_item_t;

  // whole milliseconds to microseconds, result fits THR_W for inputs up to 67108 ms
  function automatic logic [THR_W-1:0] ms_to_us(input logic [CFG_W:0] ms);
    return THR_W'(ms) * THR_W'(US_PER_MS);
  endfunction

endpackage

// ----- src/bslp_stream_if.sv -----
// valid/ready stream channel carrying one payload item per transfer
interface bslp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/button_short_long_press_top.sv -----
// Short/long press classifier over a stream of per-button level samples.
// Each sample is held in an input register, then one pass of compare logic reads
// and updates that button's state (last level, edge time, armed flag) and loads
// the result register, so a new sample is taken every cycle while the output is
// free or being drained. A result shows on the output once its sample has passed
// through the input register and the result register. Samples whose index is
// not below BUTTONS are dropped.
// The millisecond limits are turned into microsecond thresholds when written,
// so a held time is compared against them without any division.
module button_short_long_press_top #(
  parameter int unsigned BUTTONS = bslp_pkg::BUTTONS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bslp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bslp_pkg::CFG_W-1:0]     cfg_data_i,
  bslp_stream_if.sink                    in_i,
  bslp_stream_if.source                  out_o
);
  import bslp_pkg::*;

  // the index field cannot address more than INDEX_SPAN buttons
  localparam int unsigned DEPTH  = (BUTTONS < INDEX_SPAN) ? BUTTONS : INDEX_SPAN;
  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [THR_W-1:0] min_thr_q, short_thr_q, long_thr_q;

  logic              level_q [DEPTH];
  logic [TIME_W-1:0] edge_q  [DEPTH];
  logic              armed_q [DEPTH];

  logic      s1_valid_q;
  in_item_t  s1_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t out_d;

  logic              advance, in_range, fire;
  logic [SLOT_W-1:0] slot;
  logic              cur_level, cur_armed;
  logic [TIME_W-1:0] cur_edge, held_us;
  logic              rise, fall, is_short, is_long;

  // config: store thresholds in microseconds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_thr_q   <= ms_to_us({1'b0, MIN_PRESS_RST} + 17'd1);
      short_thr_q <= ms_to_us({1'b0, SHORT_LIMIT_RST});
      long_thr_q  <= ms_to_us({1'b0, LONG_LIMIT_RST} + 17'd1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_PRESS:   min_thr_q   <= ms_to_us({1'b0, cfg_data_i} + 17'd1);
        CFG_SHORT_LIMIT: short_thr_q <= ms_to_us({1'b0, cfg_data_i});
        CFG_LONG_LIMIT:  long_thr_q  <= ms_to_us({1'b0, cfg_data_i} + 17'd1);
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q <= in_i.data;
    end
  end

  assign in_range  = 32'(s1_q.button_index) < BUTTONS;
  assign slot      = s1_q.button_index[SLOT_W-1:0];
  assign fire      = s1_valid_q && in_range && advance;
  assign cur_level = level_q[slot];
  assign cur_edge  = edge_q[slot];
  assign cur_armed = armed_q[slot];
  assign held_us   = s1_q.now_us - cur_edge;
  assign rise      = s1_q.level && !cur_level;
  assign fall      = !s1_q.level && cur_level;

  // floor(us/1000) > m  <=>  us >= (m+1)*1000, and < s  <=>  us < s*1000
  assign is_short = fall && (held_us >= TIME_W'(min_thr_q))
                         && (held_us <  TIME_W'(short_thr_q));
  // an edge resets the held time to zero, so only a steady level can go long
  assign is_long  = !rise && !fall && cur_armed && (cur_edge != '0)
                    && (held_us >= TIME_W'(long_thr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        level_q[k] <= 1'b0;
        edge_q[k]  <= '0;
        armed_q[k] <= 1'b0;
      end
    end else if (fire) begin
      if (rise || fall) begin
        level_q[slot] <= s1_q.level;
        edge_q[slot]  <= s1_q.now_us;
        armed_q[slot] <= rise;
      end else if (is_long) begin
        armed_q[slot] <= 1'b0;
      end
    end
  end

  always_comb begin
    out_d.press_kind    = is_long ? KIND_LONG : KIND_SHORT;
    out_d.button_number = s1_q.button_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q && in_range && (is_short || is_long);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ----- src/bslp_checker.sv -----
// port-level checks for the press classifier, bound to the top level
module bslp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_kind_i,
  input logic [bslp_pkg::IDX_W-1:0] out_button_i
);
  import bslp_pkg::*;

  // a waiting result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
                                    && $stable(out_button_i))
    else $error("result changed while waiting for transfer");

  // input only stalls behind a result that is not being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled with output free");

  // with the pipeline empty and the output drained, no result can appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_i && !in_valid_i) ##1 (out_ready_i || !out_valid_i) |=> !out_valid_i)
    else $error("result appeared without a sample in flight");

endmodule

bind button_short_long_press_top bslp_checker u_bslp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_kind_i   (out_o.data.press_kind),
  .out_button_i (out_o.data.button_number)
);
